@@ hdl/fcsc_pkg.sv @@
`default_nettype none

package fcsc_pkg;

    localparam int SET_COUNT = 5;
    localparam int Q_W       = 16;
    localparam int MEM_W     = 17;
    localparam int PROD_W    = 33;
    localparam int BOUNDS_W  = 48;
    localparam int CFG_IDX_W = 3;

    localparam logic [MEM_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic [BOUNDS_W-1:0] BOUNDS_RST [SET_COUNT] = '{
        48'd31886265029888,
        48'd35184858634752,
        48'd40682492272128,
        48'd48379182720000,
        48'd54976353151488
    };

    // membership front end: either a direct value or a divide to run
    typedef struct packed {
        logic             direct;
        logic [MEM_W-1:0] m;
        logic [Q_W-1:0]   num;
        logic [Q_W-1:0]   den;
    } t_tri;

endpackage

`default_nettype wire

@@ hdl/fcsc_tri.sv @@
`default_nettype none

module fcsc_tri (
    input  wire logic [fcsc_pkg::Q_W-1:0]      i_x,
    input  wire logic [fcsc_pkg::BOUNDS_W-1:0] i_bounds,
    output fcsc_pkg::t_tri                     o_res
);

    logic [fcsc_pkg::Q_W-1:0] lo;
    logic [fcsc_pkg::Q_W-1:0] mid;
    logic [fcsc_pkg::Q_W-1:0] hi;

    assign lo  = i_bounds[15:0];
    assign mid = i_bounds[31:16];
    assign hi  = i_bounds[47:32];

    always_comb begin
        o_res        = '0;
        priority if (i_x < lo || i_x > hi) begin
            o_res.direct = 1'b1;
        end else if (i_x < mid) begin
            o_res.num = i_x - lo;
            o_res.den = mid - lo;
        end else if (i_x == mid) begin
            o_res.direct = 1'b1;
            o_res.m      = fcsc_pkg::ONE_Q16;
        end else begin
            o_res.num = hi - i_x;
            o_res.den = hi - mid;
        end
    end

endmodule

`default_nettype wire

@@ hdl/fcsc_div.sv @@
`default_nettype none

module fcsc_div #(
    parameter int RW = 21
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [RW-1:0]            i_rem,
    input  wire logic [fcsc_pkg::Q_W-1:0] i_low,
    input  wire logic [RW-1:0]            i_den,
    output logic                          o_done,
    output logic [fcsc_pkg::Q_W-1:0]      o_quot
);

    logic                     r_busy;
    logic                     r_done;
    logic [3:0]               r_cnt;
    logic [RW-1:0]            r_rem;
    logic [RW-1:0]            r_den;
    logic [fcsc_pkg::Q_W-1:0] r_q;

    logic [RW:0] trial;
    logic        ge;

    // restoring long division, one quotient bit per cycle
    assign trial = {r_rem, r_q[fcsc_pkg::Q_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt  <= r_cnt + 4'd1;
                r_busy <= (r_cnt != 4'(fcsc_pkg::Q_W - 1));
                r_done <= (r_cnt == 4'(fcsc_pkg::Q_W - 1));
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem;
            r_q   <= i_low;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? RW'(trial - {1'b0, r_den}) : trial[RW-1:0];
            r_q   <= {r_q[fcsc_pkg::Q_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

@@ hdl/fuzzy_centroid_set_classifier.sv @@
`default_nettype none

// Fuzzy centroid classifier over runs of Q8.8 delay samples. Each sample is
// fuzzified against five triangular sets; the peak membership and peak times
// sample are summed (at most MAX_SAMPLES samples per run). The sample marked
// tlast closes the run and yields one output transaction: the centroid, the
// first set with the greatest nonzero membership of it, and a classified flag.
// Items are handled one at a time through one shared 16-step serial divider:
// a set needs no divide when the sample is outside it or on its peak, else
// one divide; the closing sample adds the centroid divide and a second pass
// over the sets.
// An output transaction may wait on m_axis_tready while the next run starts.
module fuzzy_centroid_set_classifier #(
    parameter int MAX_SAMPLES = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [fcsc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [fcsc_pkg::BOUNDS_W-1:0]  i_cfg_data,
    // sample stream
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [15:0]                    s_axis_tdata,  // delay_sample
    input  wire logic                           s_axis_tlast,  // last_sample
    // result stream
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [23:0]                         m_axis_tdata,  // set_index, centroid
    output logic                                m_axis_tuser   // classified
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int MT_W  = fcsc_pkg::MEM_W + $clog2(MAX_SAMPLES);
    localparam int WT_W  = MT_W + fcsc_pkg::Q_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MEMB  = 3'd1;
    localparam logic [2:0] S_MWAIT = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_ACC   = 3'd4;
    localparam logic [2:0] S_CENT  = 3'd5;
    localparam logic [2:0] S_CWAIT = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [fcsc_pkg::BOUNDS_W-1:0] r_bounds [fcsc_pkg::SET_COUNT];

    logic [2:0]                  r_state;
    logic [2:0]                  r_k;
    logic                        r_cls;
    logic                        r_last;
    logic [fcsc_pkg::Q_W-1:0]    r_x;
    logic [fcsc_pkg::MEM_W-1:0]  r_best;
    logic [2:0]                  r_idx;
    logic [fcsc_pkg::PROD_W-1:0] r_prod;
    logic [WT_W-1:0]             r_wt;
    logic [MT_W-1:0]             r_mt;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_ovalid;
    logic [23:0]                 r_odata;
    logic                        r_ouser;

    fcsc_pkg::t_tri             tri_res;
    logic                       div_start;
    logic [MT_W-1:0]            div_rem;
    logic [fcsc_pkg::Q_W-1:0]   div_low;
    logic [MT_W-1:0]            div_den;
    logic                       div_done;
    logic [fcsc_pkg::Q_W-1:0]   div_quot;
    logic [fcsc_pkg::MEM_W-1:0] cand;
    logic                       step;
    logic                       upd;
    logic                       in_acc;
    logic                       out_free;

    fcsc_tri u_tri (
        .i_x      (r_x),
        .i_bounds (r_bounds[r_k]),
        .o_res    (tri_res)
    );

    fcsc_div #(
        .RW (MT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_rem   (div_rem),
        .i_low   (div_low),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ovalid || m_axis_tready;

    // divider operands: set membership or centroid
    always_comb begin
        div_start = 1'b0;
        div_rem   = MT_W'(tri_res.num);
        div_low   = '0;
        div_den   = MT_W'(tri_res.den);
        if (r_state == S_MEMB && !tri_res.direct) begin
            div_start = 1'b1;
        end else if (r_state == S_CENT && r_mt != '0) begin
            div_start = 1'b1;
            div_rem   = r_wt[WT_W-1:fcsc_pkg::Q_W];
            div_low   = r_wt[fcsc_pkg::Q_W-1:0];
            div_den   = r_mt;
        end
    end

    assign cand = (r_state == S_MEMB) ? tri_res.m : {1'b0, div_quot};
    assign step = (r_state == S_MEMB && tri_res.direct) || (r_state == S_MWAIT && div_done);
    assign upd  = cand > r_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < fcsc_pkg::SET_COUNT; i++) begin
                r_bounds[i] <= fcsc_pkg::BOUNDS_RST[i];
            end
        end else if (i_cfg_valid && o_cfg_ready
                     && i_cfg_index < fcsc_pkg::CFG_IDX_W'(fcsc_pkg::SET_COUNT)) begin
            r_bounds[i_cfg_index] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wt     <= '0;
            r_mt     <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (r_cnt < CNT_W'(MAX_SAMPLES)) begin
                            r_state <= S_MEMB;
                        end else if (s_axis_tlast) begin
                            r_state <= S_CENT;
                        end
                    end
                end
                S_MEMB: begin
                    if (!tri_res.direct) begin
                        r_state <= S_MWAIT;
                    end else if (r_k == 3'(fcsc_pkg::SET_COUNT - 1)) begin
                        r_state <= r_cls ? S_OUT : S_MUL;
                    end
                end
                S_MWAIT: begin
                    if (div_done) begin
                        if (r_k == 3'(fcsc_pkg::SET_COUNT - 1)) begin
                            r_state <= r_cls ? S_OUT : S_MUL;
                        end else begin
                            r_state <= S_MEMB;
                        end
                    end
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_wt    <= r_wt + WT_W'(r_prod);
                    r_mt    <= r_mt + MT_W'(r_best);
                    r_cnt   <= r_cnt + CNT_W'(1);
                    r_state <= r_last ? S_CENT : S_IDLE;
                end
                S_CENT: begin
                    r_state <= (r_mt != '0) ? S_CWAIT : S_MEMB;
                end
                S_CWAIT: begin
                    if (div_done) begin
                        r_state <= S_MEMB;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_wt    <= '0;
                        r_mt    <= '0;
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x    <= s_axis_tdata;
            r_last <= s_axis_tlast;
            r_cls  <= 1'b0;
            r_k    <= '0;
            r_best <= '0;
            r_idx  <= '0;
        end
        if (step) begin
            if (upd) begin
                r_best <= cand;
                r_idx  <= r_k;
            end
            if (r_k != 3'(fcsc_pkg::SET_COUNT - 1)) begin
                r_k <= r_k + 3'd1;
            end
        end
        if (r_state == S_MUL) begin
            r_prod <= {16'd0, r_best} * {17'd0, r_x};
        end
        // centroid phase: reuse the set loop on the centroid
        if ((r_state == S_CENT && r_mt == '0) || (r_state == S_CWAIT && div_done)) begin
            r_x    <= (r_state == S_CWAIT) ? div_quot : '0;
            r_cls  <= 1'b1;
            r_k    <= '0;
            r_best <= '0;
            r_idx  <= '0;
        end
        if (r_state == S_OUT && out_free) begin
            r_odata <= {5'd0, r_x, r_idx};
            r_ouser <= (r_best != '0);
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_SAMPLES))
        else $error("sample count beyond limit");

    a_best_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> r_best <= fcsc_pkg::ONE_Q16)
        else $error("membership above one");

    a_unclassified: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[2:0] == 3'd0)
        else $error("set index nonzero when unclassified");

    a_run_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> (r_cnt == '0 && r_mt == '0 && r_wt == '0))
        else $error("totals not cleared after run");
`endif

endmodule

`default_nettype wire
